// ----- hw/rtl/owm_pkg.sv -----
// Package for the one-wire bus master: codes, register map and item types.
`default_nettype none

package owm_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int unsigned TICK_W        = 11;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned CSR_DATA_W    = 10;

   // Command codes carried by req_type; the running operation uses the same codes.
   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [1:0] REQ_TICK = 2'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_RESET_TAIL    = 3'd2,
      CSR_ONE_LOW       = 3'd3,
      CSR_ZERO_LOW      = 3'd4,
      CSR_READ_LOW      = 3'd5,
      CSR_READ_SAMPLE   = 3'd6,
      CSR_SLOT          = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_wait_ticks;
      logic [9:0] reset_tail_ticks;
      logic [7:0] one_low_ticks;
      logic [7:0] zero_low_ticks;
      logic [7:0] read_low_ticks;
      logic [7:0] read_sample_ticks;
      logic [7:0] slot_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reset_low_ticks:     10'd480,
      presence_wait_ticks: 10'd70,
      reset_tail_ticks:    10'd410,
      one_low_ticks:       8'd6,
      zero_low_ticks:      8'd60,
      read_low_ticks:      8'd6,
      read_sample_ticks:   8'd9,
      slot_ticks:          8'd70
   };

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] write_data;
      logic       line_level;
   } req_item_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       device_present;
      logic       rejected;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- hw/rtl/owm_ifs.sv -----
// Handshake interfaces for the request, result and register write channels.
`default_nettype none

interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] write_data;
   logic       line_level;
   modport source (output valid, req_type, write_data, line_level, input ready);
   modport sink   (input valid, req_type, write_data, line_level, output ready);
endinterface

interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       device_present;
   logic       rejected;
   modport source (output valid, drive_low, busy_res, done_res, read_data, device_present,
                   rejected, input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, read_data, device_present,
                   rejected, output ready);
endinterface

interface owm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [9:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/owm_core.sv -----
// Bus sequencer: holds the command state and updates it once per item.
`default_nettype none

module owm_core
   import owm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   op_type               op_ff,       op_in;
   logic [TICK_W-1:0]    tick_ff,     tick_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff,  bit_idx_in;
   logic [7:0]           shift_ff,    shift_in;
   logic                 presence_ff, presence_in;
   logic                 drive_ff,    drive_in;
   logic [7:0]           rd_byte_ff,  rd_byte_in;

   logic [TICK_W-1:0]    tick_inc;
   logic [7:0]           slot_len;
   logic [7:0]           wr_low;
   logic [7:0]           rd_low;
   logic [8:0]           sample_sum;
   logic [8:0]           sample_pt;
   logic [BIT_IDX_W-1:0] bit_next;
   logic                 done;
   logic                 rejected;

   always_comb begin
      tick_inc   = tick_ff + TICK_W'(1);
      slot_len   = (cfg.slot_ticks == 8'd0) ? 8'd1 : cfg.slot_ticks;
      wr_low     = shift_ff[0] ? cfg.one_low_ticks : cfg.zero_low_ticks;
      rd_low     = (cfg.read_low_ticks == 8'd0) ? 8'd1 : cfg.read_low_ticks;
      sample_sum = {1'b0, rd_low} + {1'b0, cfg.read_sample_ticks};
      sample_pt  = (sample_sum > {1'b0, slot_len}) ? {1'b0, slot_len} : sample_sum;
      bit_next   = bit_idx_ff + BIT_IDX_W'(1);

      op_in       = op_ff;
      tick_in     = tick_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      drive_in    = drive_ff;
      rd_byte_in  = rd_byte_ff;
      done        = 1'b0;
      rejected    = 1'b0;

      if (item.req_type != REQ_TICK) begin
         if (op_ff != OP_IDLE) begin
            rejected = 1'b1;
         end else begin
            op_in      = op_type'(item.req_type);
            bit_idx_in = '0;
            drive_in   = 1'b1;
            tick_in    = '0;
            case (op_type'(item.req_type))
               OP_RESET: presence_in = 1'b0;
               OP_WRITE: shift_in    = item.write_data;
               default:  shift_in    = 8'd0;
            endcase
         end
      end else begin
         case (op_ff) inside
            OP_RESET: begin
               tick_in = tick_inc;
               if (drive_ff) begin
                  if (tick_inc >= TICK_W'(cfg.reset_low_ticks)) begin
                     drive_in = 1'b0;
                     tick_in  = '0;
                  end
               end else if (bit_idx_ff == '0) begin
                  if (tick_inc >= TICK_W'(cfg.presence_wait_ticks)) begin
                     presence_in = ~item.line_level;
                     bit_idx_in  = BIT_IDX_W'(1);
                     tick_in     = '0;
                     if (cfg.reset_tail_ticks == 10'd0) begin
                        op_in      = OP_IDLE;
                        bit_idx_in = '0;
                        done       = 1'b1;
                     end
                  end
               end else if (tick_inc >= TICK_W'(cfg.reset_tail_ticks)) begin
                  op_in      = OP_IDLE;
                  bit_idx_in = '0;
                  tick_in    = '0;
                  done       = 1'b1;
               end
            end
            OP_WRITE, OP_READ: begin
               tick_in = tick_inc;
               // The read sample lands no later than the slot close, so the last bit is kept.
               if (op_ff == OP_READ && tick_inc == TICK_W'(sample_pt)) begin
                  shift_in = {item.line_level, shift_ff[7:1]};
               end
               if (tick_inc >= TICK_W'(slot_len)) begin
                  if (op_ff == OP_WRITE) begin
                     shift_in = {1'b0, shift_ff[7:1]};
                  end
                  bit_idx_in = bit_next;
                  tick_in    = '0;
                  if (bit_next == '0) begin
                     op_in    = OP_IDLE;
                     drive_in = 1'b0;
                     done     = 1'b1;
                     if (op_ff == OP_READ) begin
                        rd_byte_in = shift_in;
                     end
                  end else begin
                     drive_in = 1'b1;
                  end
               end else if (tick_inc >= TICK_W'((op_ff == OP_WRITE) ? wr_low : rd_low)) begin
                  drive_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      result.drive_low      = drive_in;
      result.busy_res       = (op_in != OP_IDLE);
      result.done_res       = done;
      result.read_data      = rd_byte_in;
      result.device_present = presence_in;
      result.rejected       = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b0;
         drive_ff    <= 1'b0;
         rd_byte_ff  <= '0;
      end else if (advance) begin
         op_ff       <= op_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         drive_ff    <= drive_in;
         rd_byte_ff  <= rd_byte_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/one_wire_bus_master_top.sv -----
// Top level of the one-wire bus master: input register, registers and result queue.
//
//   Channel   Direction  Handshake      Contents
//   req_bus   in         valid/ready    req_type, write_data, line_level
//   rsp_bus   out        valid/ready    drive_low, busy_res, done_res, read_data,
//                                       device_present, rejected
//   csr_bus   in         valid/ready    index, data (register write)
//
// One item is taken per cycle unless the result queue is full and unread; its result
// passes the input register, then the sequencer update into a two-entry result queue.
// The queue lets the input keep moving while one result waits to be taken.
// Reset is synchronous and restores the default timing registers and idle state.
// Register writes are always accepted and apply at once.
`default_nettype none

module one_wire_bus_master_top
   import owm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   owm_req_if.sink   req_bus,
   owm_rsp_if.source rsp_bus,
   owm_csr_if.sink   csr_bus
);

   cfg_type      cfg_ff;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type q0_ff, q1_ff;
   logic         q0_valid_ff, q1_valid_ff;
   rsp_item_type result;
   logic         advance;
   logic         pop;
   logic         req_take;

   assign pop      = q0_valid_ff & rsp_bus.ready;
   assign advance  = in_valid_ff & (~q1_valid_ff | pop);
   assign req_take = req_bus.valid & req_bus.ready;

   assign req_bus.ready = ~in_valid_ff | advance;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = q0_valid_ff;
   assign rsp_bus.drive_low      = q0_ff.drive_low;
   assign rsp_bus.busy_res       = q0_ff.busy_res;
   assign rsp_bus.done_res       = q0_ff.done_res;
   assign rsp_bus.read_data      = q0_ff.read_data;
   assign rsp_bus.device_present = q0_ff.device_present;
   assign rsp_bus.rejected       = q0_ff.rejected;

   owm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_idx_type'(csr_bus.index))
            CSR_RESET_LOW:     cfg_ff.reset_low_ticks     <= csr_bus.data;
            CSR_PRESENCE_WAIT: cfg_ff.presence_wait_ticks <= csr_bus.data;
            CSR_RESET_TAIL:    cfg_ff.reset_tail_ticks    <= csr_bus.data;
            CSR_ONE_LOW:       cfg_ff.one_low_ticks       <= csr_bus.data[7:0];
            CSR_ZERO_LOW:      cfg_ff.zero_low_ticks      <= csr_bus.data[7:0];
            CSR_READ_LOW:      cfg_ff.read_low_ticks      <= csr_bus.data[7:0];
            CSR_READ_SAMPLE:   cfg_ff.read_sample_ticks   <= csr_bus.data[7:0];
            CSR_SLOT:          cfg_ff.slot_ticks          <= csr_bus.data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_take) begin
         in_item_ff.req_type   <= req_bus.req_type;
         in_item_ff.write_data <= req_bus.write_data;
         in_item_ff.line_level <= req_bus.line_level;
      end
   end

   // Two-entry result queue: entry 0 is the head shown on the output.
   always_ff @(posedge clock) begin
      if (reset) begin
         q0_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            if (q1_valid_ff) begin
               q0_ff       <= q1_ff;
               q1_valid_ff <= advance;
               if (advance) begin
                  q1_ff <= result;
               end
            end else begin
               q0_valid_ff <= advance;
               if (advance) begin
                  q0_ff <= result;
               end
            end
         end else if (advance) begin
            if (q0_valid_ff) begin
               q1_ff       <= result;
               q1_valid_ff <= 1'b1;
            end else begin
               q0_ff       <= result;
               q0_valid_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire
